>>> rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg: shared types and constants of the diffusion stencil pass
// Pixel type, stencil window bundle, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ids_pkg;

    typedef logic [15:0] t_pix;

    // One stencil window as handed from the cell row to the arithmetic pipe
    typedef struct packed {
        t_pix up;
        t_pix left;
        t_pix centre;
        t_pix right;
        t_pix down;
        logic border;   // copy the centre unchanged
        logic last;     // final pixel of the frame
    } t_win;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_RATE = 2'd2;

    localparam logic [10:0] FRAME_WIDTH_RST    = 11'd1024;
    localparam logic [12:0] FRAME_HEIGHT_RST   = 13'd1024;
    localparam logic [14:0] DIFFUSION_RATE_RST = 15'd6554;

    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

endpackage

`default_nettype wire

>>> rtl/ids_cell.sv
// ----------------------------------------------------------------------------
// ids_cell: one tap of the stencil window
// Holds one pixel; on shift it takes either its neighbour's value or a
// fresh value read from the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_cell
    import ids_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_shift,
    input  wire  i_load_side,
    input  t_pix i_chain,
    input  t_pix i_side,
    output t_pix o_q
);

    t_pix r_q;
    t_pix n_q;

    always_comb begin
        n_q = i_load_side ? i_side : i_chain;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

>>> rtl/ids_kernel.sv
// ----------------------------------------------------------------------------
// ids_kernel: diffusion arithmetic pipeline
// Laplacian, scale by kappa, round half up and saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_kernel
    import ids_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  t_win        i_win,
    input  wire  [14:0] i_rate,
    output logic        o_valid,
    input  wire         i_ready,
    output t_pix        o_pixel,
    output logic        o_last
);

    // stage A: laplacian
    logic               r_av;
    logic signed [18:0] r_a_lap;
    t_pix               r_a_c;
    logic               r_a_border;
    logic               r_a_last;
    // stage B: product
    logic               r_bv;
    logic signed [34:0] r_b_prod;
    t_pix               r_b_c;
    logic               r_b_border;
    logic               r_b_last;
    // output register
    logic               r_ov;
    t_pix               r_o_pix;
    logic               r_o_last;

    logic               adv_o;
    logic               adv_b;
    logic               adv_a;
    logic        [17:0] nb_sum;
    logic signed [18:0] n_lap;
    logic signed [34:0] n_prod;
    logic signed [35:0] t_acc;
    t_pix               n_pix;

    assign adv_o   = !r_ov || i_ready;
    assign adv_b   = !r_bv || adv_o;
    assign adv_a   = !r_av || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        nb_sum = 18'(i_win.up) + 18'(i_win.left) + 18'(i_win.right) + 18'(i_win.down);
        n_lap  = $signed({1'b0, nb_sum}) - $signed({1'b0, i_win.centre, 2'b00});
    end

    always_comb begin
        n_prod = $signed({1'b0, i_rate}) * r_a_lap;
    end

    always_comb begin
        t_acc = $signed({4'b0000, r_b_c, 16'h0000}) + {r_b_prod[34], r_b_prod}
              + 36'sd32768;
        if (r_b_border) begin
            n_pix = r_b_c;
        end else if (t_acc[35]) begin
            n_pix = '0;
        end else if (|t_acc[34:32]) begin
            n_pix = '1;
        end else begin
            n_pix = t_acc[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv_a) r_av <= i_valid;
            if (adv_b) r_bv <= r_av;
            if (adv_o) r_ov <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_a_lap    <= n_lap;
            r_a_c      <= i_win.centre;
            r_a_border <= i_win.border;
            r_a_last   <= i_win.last;
        end
        if (adv_b && r_av) begin
            r_b_prod   <= n_prod;
            r_b_c      <= r_a_c;
            r_b_border <= r_a_border;
            r_b_last   <= r_a_last;
        end
        if (adv_o && r_bv) begin
            r_o_pix    <= n_pix;
            r_o_last   <= r_b_last;
        end
    end

    assign o_valid = r_ov;
    assign o_pixel = r_o_pix;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

>>> rtl/isotropic_diffusion_stencil_pass.sv
// ----------------------------------------------------------------------------
// isotropic_diffusion_stencil_pass: one explicit diffusion step, streamed
// Five-point stencil over a raster-order frame with a two-row line store.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps that rate as long as the
// result side keeps up; results travel through a five-register pipeline
// (line-store read, window cells, laplacian, kappa product, round and
// saturate) and are presented when the pixel below them has passed that
// pipeline, about one frame row after their own pixel. The line store is a
// single memory with one write and two read ports: each pixel writes itself
// and reads the centre row ahead and the row above, and the window cells
// hand left, centre and right along the row.
// Border rows and columns leave unchanged. After the last pixel of a frame
// send frame_width items with tuser set to flush the final row; the last of
// them carries tlast. Pixels in that flush phase and flush items outside it
// are taken and dropped. Write configuration only while no results are
// outstanding; the configuration port is always ready.
`default_nettype none

module isotropic_diffusion_stencil_pass
    import ids_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [15:0]            s_axis_tdata,   // [15:0] pixel_in
    input  wire [0:0]             s_axis_tuser,   // [0] drain
    // result stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [15:0] pixel_out
    output logic                  m_axis_tlast    // frame_last
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(2 * MAX_WIDTH);

    function automatic logic [AW-1:0] slot_addr(input logic par, input logic [CW-1:0] cv);
        logic [AW-1:0] base;
        base = par ? AW'(MAX_WIDTH) : '0;
        return base + AW'(cv);
    endfunction

    // configuration
    logic [10:0]   r_frame_width;
    logic [12:0]   r_frame_height;
    logic [14:0]   r_diff_rate;

    // frame position
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic          r_drain_phase;

    t_pix          mem [2*MAX_WIDTH];

    // stage 1: line-store read
    logic          r_v1;
    logic          r_s1_border;
    logic          r_s1_last;
    logic          r_s1_reload;
    t_pix          r_s1_down;
    t_pix          r_rd_a;
    t_pix          r_rd_b;

    // stage 2: window cells plus up/down
    logic          r_v2;
    t_pix          r_s2_up;
    t_pix          r_s2_down;
    logic          r_s2_border;
    logic          r_s2_last;

    logic [WCW-1:0] w_eff;
    logic [12:0]    h_eff;
    logic [CW-1:0]  col_now;
    logic [11:0]    row_now;
    logic [CW:0]    col_p1;
    logic [12:0]    row_p1;
    logic [CW-1:0]  col_nx;
    logic           last_col;
    logic           last_row;
    logic           interior;
    logic           drain;
    logic           accept;
    logic           emit;
    logic           wr_en;
    logic [AW-1:0]  addr_a;
    logic [AW-1:0]  addr_b;
    logic [AW-1:0]  addr_w;
    logic           adv1;
    logic           adv2;
    logic           shift;
    logic           k_ready;
    t_pix           q_left;
    t_pix           q_centre;
    t_pix           q_right;
    t_win           win;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_diff_rate    <= DIFFUSION_RATE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data[12:0];
                CFG_DIFFUSION_RATE: r_diff_rate    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (r_frame_width < 11'(MIN_SIZE)) begin
            w_eff = WCW'(MIN_SIZE);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(r_frame_width);
        end
        if (r_frame_height < 13'(MIN_SIZE)) begin
            h_eff = 13'(MIN_SIZE);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = 13'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // position of the item at the port; wrap counters past a shrunk size
    always_comb begin
        col_now  = ((CW+1)'(r_col) >= (CW+1)'(w_eff)) ? '0 : r_col;
        row_now  = (13'(r_row) >= h_eff) ? '0 : r_row;
        col_p1   = {1'b0, col_now} + 1'b1;
        row_p1   = {1'b0, row_now} + 1'b1;
        last_col = col_p1 >= (CW+1)'(w_eff);
        last_row = row_p1 >= h_eff;
        col_nx   = last_col ? col_now : col_p1[CW-1:0];
        interior = (row_now >= 12'd2) && (col_now != '0) && !last_col;
    end

    assign drain  = s_axis_tuser[0];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign emit   = r_drain_phase ? drain : (!drain && (row_now != '0));
    assign wr_en  = accept && !r_drain_phase && !drain;

    // port A: centre of a reload (column 0, flush) or the row above otherwise
    always_comb begin
        if (r_drain_phase) begin
            addr_a = slot_addr(~h_eff[0], col_now);
        end else if (col_now == '0) begin
            addr_a = slot_addr(~row_now[0], '0);
        end else begin
            addr_a = slot_addr(row_now[0], col_now);
        end
        addr_b = slot_addr(~row_now[0], col_nx);
        addr_w = slot_addr(row_now[0], col_now);
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_rd_a <= mem[addr_a];
            r_rd_b <= mem[addr_b];
        end
        if (wr_en) begin
            mem[addr_w] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_drain_phase <= 1'b0;
        end else if (accept) begin
            if (r_drain_phase) begin
                if (drain) begin
                    if (last_col) begin
                        r_col         <= '0;
                        r_row         <= '0;
                        r_drain_phase <= 1'b0;
                    end else begin
                        r_col <= col_p1[CW-1:0];
                    end
                end
            end else if (!drain) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row         <= '0;
                        r_drain_phase <= 1'b1;
                    end else begin
                        r_row <= row_p1[11:0];
                    end
                end else begin
                    r_col <= col_p1[CW-1:0];
                end
            end
        end
    end

    // pipeline advance: a stage moves when the one after it is empty or moving
    assign adv2          = !r_v2 || k_ready;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign shift         = r_v1 && adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= accept && emit;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_border <= r_drain_phase || !interior;
            r_s1_last   <= r_drain_phase && last_col;
            r_s1_reload <= r_drain_phase || (col_now == '0);
            r_s1_down   <= s_axis_tdata;
        end
        if (shift) begin
            r_s2_up     <= r_rd_a;
            r_s2_down   <= r_s1_down;
            r_s2_border <= r_s1_border;
            r_s2_last   <= r_s1_last;
        end
    end

    // window cells: right always reloads, centre reloads at row start and flush
    ids_cell u_cell_right (
        .i_clk       (i_clk),
        .i_shift     (shift),
        .i_load_side (1'b1),
        .i_chain     (q_right),
        .i_side      (r_rd_b),
        .o_q         (q_right)
    );

    ids_cell u_cell_centre (
        .i_clk       (i_clk),
        .i_shift     (shift),
        .i_load_side (r_s1_reload),
        .i_chain     (q_right),
        .i_side      (r_rd_a),
        .o_q         (q_centre)
    );

    ids_cell u_cell_left (
        .i_clk       (i_clk),
        .i_shift     (shift),
        .i_load_side (1'b0),
        .i_chain     (q_centre),
        .i_side      (r_rd_a),
        .o_q         (q_left)
    );

    always_comb begin
        win.up     = r_s2_up;
        win.left   = q_left;
        win.centre = q_centre;
        win.right  = q_right;
        win.down   = r_s2_down;
        win.border = r_s2_border;
        win.last   = r_s2_last;
    end

    ids_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (k_ready),
        .i_win   (win),
        .i_rate  (r_diff_rate),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/ids_checker.sv
// ----------------------------------------------------------------------------
// ids_checker: port-level checks of the diffusion stencil pass
// Output register behaviour and flow-through of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // with nothing waiting at the output every stage can move, so input is open
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    // a refused result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a lone result cannot block the input
    a_single_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind isotropic_diffusion_stencil_pass ids_checker u_ids_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
